### src/ihex_pkg.sv
package ihex_pkg;

	localparam int LEN_W          = 5;
	localparam int RECORD_MAX_DEF = 16;
	localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

	localparam logic [6:0] CHAR_COLON = 7'h3A;
	localparam logic [6:0] CHAR_NL    = 7'h0A;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_ONE   = 7'h31;
	localparam logic [6:0] CHAR_F     = 7'h46;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COLON,
		ST_CNT,
		ST_ADDR,
		ST_TYPE,
		ST_DATA,
		ST_SUM,
		ST_NL,
		ST_EOF
	} state_t;

	typedef struct packed {
		state_t phase;
		logic   accept;
		logic   emit;
		logic   last;
		logic   step_clr;
		logic   fin_rec;
		logic   fin_eof;
	} cmd_t;

	typedef struct packed {
		logic need_rec;
		logic step_last;
		logic out_free;
		logic eod_q;
	} status_t;

	function automatic logic [6:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return CHAR_ZERO + {3'b000, n};
		else
			return 7'h37 + {3'b000, n};
	endfunction

	// text of the end record, one character per step
	function automatic logic [6:0] eof_char(input logic [3:0] i);
		logic [6:0] c;
		case (i) inside
			4'd0:          c = CHAR_COLON;
			[4'd1:4'd7]:   c = CHAR_ZERO;
			4'd8:          c = CHAR_ONE;
			4'd9, 4'd10:   c = CHAR_F;
			default:       c = CHAR_ZERO;
		endcase
		return c;
	endfunction

endpackage

### src/ihex_ctrl.sv
module ihex_ctrl
	import ihex_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (st.need_rec)
						state_d = ST_COLON;
					else if (st.eod_q)
						state_d = ST_EOF;
				end
			end
			ST_COLON: if (st.out_free && st.step_last) state_d = ST_CNT;
			ST_CNT:   if (st.out_free && st.step_last) state_d = ST_ADDR;
			ST_ADDR:  if (st.out_free && st.step_last) state_d = ST_TYPE;
			ST_TYPE:  if (st.out_free && st.step_last) state_d = ST_DATA;
			ST_DATA:  if (st.out_free && st.step_last) state_d = ST_SUM;
			ST_SUM:   if (st.out_free && st.step_last) state_d = ST_NL;
			ST_NL: begin
				if (st.out_free && st.step_last)
					state_d = st.eod_q ? ST_EOF : ST_IDLE;
			end
			ST_EOF:   if (st.out_free && st.step_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// in idle, eod_q shows the end flag of the beat on the input port
	always_comb begin
		cmd          = '0;
		cmd.phase    = state_q;
		in_stall     = (state_q != ST_IDLE);
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.emit     = (state_q != ST_IDLE) && st.out_free;
		cmd.step_clr = cmd.emit && st.step_last;
		cmd.fin_rec  = cmd.step_clr && (state_q == ST_NL);
		cmd.fin_eof  = cmd.step_clr && (state_q == ST_EOF);
		cmd.last     = ((state_q == ST_NL) && !st.eod_q && st.step_last) ||
		               ((state_q == ST_EOF) && st.step_last);
	end

endmodule

### src/ihex_datapath.sv
module ihex_datapath
	import ihex_pkg::*;
#(
	parameter int RECORD_MAX = RECORD_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  logic             byte_valid,
	input  logic             end_of_data,
	input  logic             wr_en,
	input  logic [LEN_W-1:0] wr_data,
	input  cmd_t             cmd,
	output status_t          st,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [6:0]       ascii_char,
	output logic             last_of_run
);

	localparam int FILL_W  = $clog2(RECORD_MAX + 1);
	localparam int IDX_W   = (RECORD_MAX > 1) ? $clog2(RECORD_MAX) : 1;
	localparam int STEPS   = (2 * RECORD_MAX > 11) ? 2 * RECORD_MAX : 11;
	localparam int STEP_W  = $clog2(STEPS);

	logic [7:0]        buf_q [RECORD_MAX];
	logic [FILL_W-1:0] fill_q;
	logic [15:0]       addr_q;
	logic [7:0]        sum_q;
	logic [LEN_W-1:0]  len_q;
	logic              eod_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [6:0]        char_q;
	logic              last_q;

	logic [FILL_W-1:0] len_eff;
	logic              room;
	logic [FILL_W-1:0] fill_next;
	logic [7:0]        cnt_byte;
	logic [7:0]        chk;
	logic [STEP_W-1:0] byte_sel;
	logic [STEP_W-1:0] data_last;
	logic [7:0]        cur_byte;
	logic [3:0]        nib;
	logic [6:0]        char_d;
	logic              out_free;

	// zero acts as one, anything above the buffer depth as the depth
	always_comb begin
		if (len_q == '0)
			len_eff = FILL_W'(1);
		else if (len_q > LEN_W'(RECORD_MAX))
			len_eff = FILL_W'(RECORD_MAX);
		else
			len_eff = FILL_W'(len_q);
	end

	assign room      = (fill_q < FILL_W'(RECORD_MAX));
	assign fill_next = fill_q + FILL_W'(byte_valid && room);
	assign cnt_byte  = 8'(fill_q);
	assign chk       = 8'h00 - (8'(fill_q) + addr_q[15:8] + addr_q[7:0] + sum_q);
	assign byte_sel  = step_q >> 1;
	assign data_last = STEP_W'({1'b0, fill_q, 1'b0} - (FILL_W + 1)'(1));
	assign cur_byte  = buf_q[byte_sel[IDX_W-1:0]];
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		nib    = 4'h0;
		char_d = CHAR_ZERO;
		case (cmd.phase)
			ST_COLON: char_d = CHAR_COLON;
			ST_CNT: begin
				nib    = step_q[0] ? cnt_byte[3:0] : cnt_byte[7:4];
				char_d = hex_char(nib);
			end
			ST_ADDR: begin
				case (step_q[1:0])
					2'd0:    nib = addr_q[15:12];
					2'd1:    nib = addr_q[11:8];
					2'd2:    nib = addr_q[7:4];
					default: nib = addr_q[3:0];
				endcase
				char_d = hex_char(nib);
			end
			ST_TYPE: char_d = CHAR_ZERO;
			ST_DATA: begin
				nib    = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
				char_d = hex_char(nib);
			end
			ST_SUM: begin
				nib    = step_q[0] ? chk[3:0] : chk[7:4];
				char_d = hex_char(nib);
			end
			ST_NL:   char_d = CHAR_NL;
			ST_EOF:  char_d = eof_char(step_q[3:0]);
			default: char_d = CHAR_ZERO;
		endcase
	end

	always_comb begin
		st          = '0;
		st.out_free = out_free;
		// in idle the end flag comes straight from the input beat
		st.eod_q    = (cmd.phase == ST_IDLE) ? end_of_data : eod_q;
		st.need_rec = (byte_valid && (fill_next >= len_eff)) ||
		              (end_of_data && (fill_next != '0));
		case (cmd.phase)
			ST_COLON: st.step_last = 1'b1;
			ST_CNT:   st.step_last = (step_q == STEP_W'(1));
			ST_ADDR:  st.step_last = (step_q == STEP_W'(3));
			ST_TYPE:  st.step_last = (step_q == STEP_W'(1));
			ST_DATA:  st.step_last = (step_q == data_last);
			ST_SUM:   st.step_last = (step_q == STEP_W'(1));
			ST_NL:    st.step_last = 1'b1;
			ST_EOF:   st.step_last = (step_q == STEP_W'(10));
			default:  st.step_last = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && byte_valid && room)
			buf_q[fill_q[IDX_W-1:0]] <= data_byte;
		if (cmd.emit) begin
			char_q <= char_d;
			last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			addr_q      <= '0;
			sum_q       <= '0;
			len_q       <= LEN_RESET;
			eod_q       <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en)
				len_q <= wr_data;
			if (cmd.accept) begin
				eod_q  <= end_of_data;
				fill_q <= fill_next;
				if (byte_valid && room)
					sum_q <= sum_q + data_byte;
			end
			if (cmd.fin_rec) begin
				addr_q <= addr_q + 16'(fill_q);
				fill_q <= '0;
				sum_q  <= '0;
			end
			if (cmd.fin_eof) begin
				addr_q <= '0;
				fill_q <= '0;
				sum_q  <= '0;
			end
			if (cmd.step_clr)
				step_q <= '0;
			else if (cmd.emit)
				step_q <= step_q + STEP_W'(1);
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign ascii_char  = char_q;
	assign last_of_run = last_q;

endmodule

### src/intel_hex_record_encoder.sv
// Intel HEX record encoder: bytes beat in one at a time and are gathered into a record of
// record_length bytes (0 acts as 1, above RECORD_MAX as RECORD_MAX); a full record, or the
// partial record at end_of_data, leaves as ASCII text one character per output beat, and
// end_of_data adds the end record ":00000001FF". A byte that closes no record is taken
// without holding the input; a beat that produces text holds the input until all of its
// text is issued, as the single character output register delivers one character per
// cycle while out_stall is low. last_of_run marks the final character of the text of
// each input beat. Write record_length through wr_en/wr_data only while the block is idle.
module intel_hex_record_encoder
	import ihex_pkg::*;
#(
	parameter int RECORD_MAX = RECORD_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             byte_valid,
	input  logic             end_of_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [6:0]       ascii_char,
	output logic             last_of_run,
	input  logic             wr_en,
	input  logic [LEN_W-1:0] wr_data
);

	cmd_t    cmd;
	status_t st;

	ihex_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	ihex_datapath #(
		.RECORD_MAX (RECORD_MAX)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.end_of_data (end_of_data),
		.wr_en       (wr_en),
		.wr_data     (wr_data),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ascii_char  (ascii_char),
		.last_of_run (last_of_run)
	);

endmodule
